/* src/mrq_pkg.sv */
// ============================================================================
// mrq_pkg: shared types and codes for the multi-ring queue engine
// Holds the request and result item layouts, the configuration bundle, the
// operation and status codes and the register map of the configuration port.
// ============================================================================
package mrq_pkg;

    // Operations carried in the cmd field.
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;
    localparam logic [1:0] CMD_CLEAR   = 2'd3;

    // Result status codes.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_INVALID   = 2'd1;
    localparam logic [1:0] STS_OVERFLOW  = 2'd2;
    localparam logic [1:0] STS_UNDERFLOW = 2'd3;

    // Configuration register map, one 32-bit word per register.
    localparam int         CFG_ADDR_W    = 4;
    localparam logic [1:0] REG_CAPACITY  = 2'd0;
    localparam logic [1:0] REG_ENABLE    = 2'd1;
    localparam logic [1:0] REG_OVERWRITE = 2'd2;

    localparam logic [6:0] CAPACITY_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  queue_id;
        logic [31:0] data_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data_out;
        logic [6:0]  count;
        logic [6:0]  free_space;
    } rsp_t;

    // Configuration as seen by the datapath, plus the one-cycle pulse of
    // enable bits that the current write takes from clear to set.
    typedef struct packed {
        logic [6:0] capacity;
        logic [7:0] enabled;
        logic [7:0] overwrite;
        logic [7:0] enable_rise;
    } cfg_t;

endpackage

/* src/mrq_regs.sv */
// ============================================================================
// mrq_regs: configuration register file
// APB-style slave holding the capacity, enable and overwrite registers.
// ============================================================================
module mrq_regs
    import mrq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [6:0] capacity_reg;
    logic [7:0] enabled_reg;
    logic [7:0] overwrite_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= CAPACITY_RESET;
            enabled_reg   <= '0;
            overwrite_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_CAPACITY:  capacity_reg  <= pwdata[6:0];
                REG_ENABLE:    enabled_reg   <= pwdata[7:0];
                REG_OVERWRITE: overwrite_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_CAPACITY:  prdata = {25'd0, capacity_reg};
            REG_ENABLE:    prdata = {24'd0, enabled_reg};
            REG_OVERWRITE: prdata = {24'd0, overwrite_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        cfg.capacity    = capacity_reg;
        cfg.enabled     = enabled_reg;
        cfg.overwrite   = overwrite_reg;
        cfg.enable_rise = (wr_en && reg_idx == REG_ENABLE) ?
                          (pwdata[7:0] & ~enabled_reg) : 8'd0;
    end

endmodule

/* src/mrq_ptr_table.sv */
// ============================================================================
// mrq_ptr_table: per-queue pointer memory
// Synchronous memory of {head, tail, count} per queue with a valid bit per
// entry; an entry that is not valid reads as zero (a fresh queue).
// ============================================================================
module mrq_ptr_table
    import mrq_pkg::*;
#(
    parameter int NUM_QUEUES = 8,
    parameter int ENTRY_W    = 19,
    parameter int QW         = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [QW-1:0]      rd_addr,
    output logic [ENTRY_W-1:0] rd_data,
    input  logic               wr_en,
    input  logic [QW-1:0]      wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic [7:0]         clr_mask
);

    localparam int NQ_EXT = (NUM_QUEUES > 8) ? NUM_QUEUES : 8;

    logic [ENTRY_W-1:0]    mem [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] vld_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_vld_reg;
    logic [NQ_EXT-1:0]     clr_ext;

    assign clr_ext = NQ_EXT'(clr_mask);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (clr_ext[q]) begin
                    vld_reg[q] <= 1'b0;
                end else if (wr_en && wr_addr == QW'(q)) begin
                    vld_reg[q] <= 1'b1;
                end
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* src/mrq_storage.sv */
// ============================================================================
// mrq_storage: shared element store
// One synchronous memory holding every queue's ring, registered read data.
// ============================================================================
module mrq_storage
    import mrq_pkg::*;
#(
    parameter int DEPTH      = 512,
    parameter int AW         = 9,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/multi_ring_queue_engine.sv */
// ============================================================================
// multi_ring_queue_engine: several ring-buffer queues in one shared store
// Top level: request sequencer, pointer table, element store and registers.
// ============================================================================
// How to use this block:
// Requests enter on the s_ channel (valid/ready) as one item each: an enqueue,
// dequeue, peek or clear aimed at one queue. Every request gives exactly one
// result item on the m_ channel with a status, the front element for a
// successful dequeue or peek, and the queue's count and free space afterwards.
// The configuration port sets the shared capacity, the enable mask and the
// overwrite mask; write it only while no request is in flight. Setting an
// enable bit that was clear starts that queue empty.
// Each accepted request goes through state S_PTR, where its pointers are read and
// updated, and state S_RES, where the element store read data is taken, before
// its result is loaded into the output register. One request is worked at a
// time, as the pointer table read and the element store read are two dependent
// memory accesses; no new item is accepted until the last result is loaded.
// The output register lets the next request be accepted while a result waits;
// when the receiver stalls, the finished result of that next request waits
// inside the block and no further item is accepted until the output frees.
// Reset (aresetn low, synchronous) empties every queue through the pointer
// table's valid bits and restores the register reset values; the element
// store keeps its contents, which are never read before being written.
// ============================================================================
module multi_ring_queue_engine
    import mrq_pkg::*;
#(
    parameter int NUM_QUEUES  = 8,
    parameter int QUEUE_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  req_t                  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rsp_t                  m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    // Ring index width, queue-select width and pointer entry layout.
    localparam int IW      = $clog2(QUEUE_DEPTH);
    localparam int QW      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int ENTRY_W = 2 * IW + 7;
    localparam int SDEPTH  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int SAW     = $clog2(SDEPTH);
    // Wide enough to compare an incremented index against the capacity.
    localparam int AW      = ((IW > 7) ? IW : 7) + 1;
    localparam int CAP_MAX = (QUEUE_DEPTH < 127) ? QUEUE_DEPTH : 127;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PTR  = 2'd1;
    localparam logic [1:0] S_RES  = 2'd2;

    cfg_t cfg;

    logic [1:0]   state_reg, state_next;
    req_t         req_reg, req_next;
    logic [1:0]   sts_reg, sts_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [6:0]   free_reg, free_next;
    logic         rdval_reg, rdval_next;
    logic         m_valid_reg, m_valid_next;
    rsp_t         m_data_reg, m_data_next;

    logic [ENTRY_W-1:0]    ptr_rd_data;
    logic [ENTRY_W-1:0]    ptr_wr_data;
    logic                  ptr_wr_en;
    logic                  ptr_rd_en;
    logic [IW-1:0]         cur_head, cur_tail, new_head, new_tail;
    logic [6:0]            cur_cnt, new_cnt;
    logic [6:0]            cap_eff;
    logic [15:0]           en16, ovw16;
    logic                  handle_ok;
    logic                  is_full;
    logic [QW-1:0]         req_q;

    logic                  st_wr_en, st_rd_en;
    logic [IW-1:0]         st_idx;
    logic [SAW-1:0]        st_addr;
    logic [DATA_WIDTH-1:0] st_rd_data;
    logic                  out_free;

    function automatic logic [IW-1:0] advance(input logic [IW-1:0] idx,
                                              input logic [6:0] cap);
        logic [AW-1:0] nxt;
        nxt = AW'(idx) + AW'(1);
        return (nxt >= AW'(cap)) ? '0 : IW'(nxt);
    endfunction

    mrq_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mrq_ptr_table #(
        .NUM_QUEUES (NUM_QUEUES),
        .ENTRY_W    (ENTRY_W),
        .QW         (QW)
    ) u_ptr_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (ptr_rd_en),
        .rd_addr  (s_data.queue_id[QW-1:0]),
        .rd_data  (ptr_rd_data),
        .wr_en    (ptr_wr_en),
        .wr_addr  (req_q),
        .wr_data  (ptr_wr_data),
        .clr_mask (cfg.enable_rise)
    );

    mrq_storage #(
        .DEPTH      (SDEPTH),
        .AW         (SAW),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_storage (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_addr),
        .wr_data (DATA_WIDTH'(req_reg.data_in)),
        .rd_en   (st_rd_en),
        .rd_addr (st_addr),
        .rd_data (st_rd_data)
    );

    // Capacity of zero behaves as one; anything above the ring size is clamped.
    always_comb begin
        if (cfg.capacity == 7'd0) begin
            cap_eff = 7'd1;
        end else if (cfg.capacity > 7'(CAP_MAX)) begin
            cap_eff = 7'(CAP_MAX);
        end else begin
            cap_eff = cfg.capacity;
        end
    end

    assign en16      = 16'(cfg.enabled);
    assign ovw16     = 16'(cfg.overwrite);
    assign req_q     = req_reg.queue_id[QW-1:0];
    assign handle_ok = (5'(req_reg.queue_id) < 5'(NUM_QUEUES)) && en16[req_reg.queue_id];

    assign s_ready   = (state_reg == S_IDLE);
    assign ptr_rd_en = s_valid && s_ready;
    assign {cur_head, cur_tail, cur_cnt} = ptr_rd_data;
    assign is_full   = (cur_cnt >= cap_eff);
    assign st_addr   = SAW'(req_q) * SAW'(QUEUE_DEPTH) + SAW'(st_idx);
    assign out_free  = !m_valid_reg || m_ready;

    // Read-modify-write of the queue's pointers while the pointer read is
    // on the table's output; the element access is issued in the same cycle.
    always_comb begin
        new_head  = cur_head;
        new_tail  = cur_tail;
        new_cnt   = cur_cnt;
        ptr_wr_en = 1'b0;
        st_wr_en  = 1'b0;
        st_rd_en  = 1'b0;
        st_idx    = cur_tail;
        sts_next  = STS_OK;
        if (state_reg == S_PTR) begin
            if (!handle_ok) begin
                sts_next = STS_INVALID;
            end else begin
                case (req_reg.cmd)
                    CMD_ENQUEUE: begin
                        if (is_full && !ovw16[req_reg.queue_id]) begin
                            sts_next = STS_OVERFLOW;
                        end else begin
                            if (is_full) begin
                                // Overwrite drops the oldest entry.
                                new_tail = advance(cur_tail, cap_eff);
                            end else begin
                                new_cnt = cur_cnt + 7'd1;
                            end
                            new_head  = advance(cur_head, cap_eff);
                            st_idx    = cur_head;
                            st_wr_en  = 1'b1;
                            ptr_wr_en = 1'b1;
                        end
                    end
                    CMD_DEQUEUE, CMD_PEEK: begin
                        if (cur_cnt == 7'd0) begin
                            sts_next = STS_UNDERFLOW;
                        end else begin
                            st_rd_en = 1'b1;
                            if (req_reg.cmd == CMD_DEQUEUE) begin
                                new_tail  = advance(cur_tail, cap_eff);
                                new_cnt   = cur_cnt - 7'd1;
                                ptr_wr_en = 1'b1;
                            end
                        end
                    end
                    CMD_CLEAR: begin
                        new_head  = '0;
                        new_tail  = '0;
                        new_cnt   = '0;
                        ptr_wr_en = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign ptr_wr_data = {new_head, new_tail, new_cnt};

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        cnt_next     = cnt_reg;
        free_next    = free_reg;
        rdval_next   = rdval_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = S_PTR;
                end
            end
            S_PTR: begin
                rdval_next = st_rd_en;
                if (handle_ok) begin
                    cnt_next  = new_cnt;
                    free_next = (new_cnt >= cap_eff) ? 7'd0 : cap_eff - new_cnt;
                end else begin
                    cnt_next  = 7'd0;
                    free_next = 7'd0;
                end
                state_next = S_RES;
            end
            S_RES: begin
                // The element store holds its read data until the result leaves.
                if (out_free) begin
                    m_data_next.status     = sts_reg;
                    m_data_next.data_out   = rdval_reg ? 32'(st_rd_data) : 32'd0;
                    m_data_next.count      = cnt_reg;
                    m_data_next.free_space = free_reg;
                    m_valid_next           = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        cnt_reg    <= cnt_next;
        free_reg   <= free_next;
        rdval_reg  <= rdval_next;
        m_data_reg <= m_data_next;
        if (state_reg == S_PTR) begin
            sts_reg <= sts_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
